@@ sv/tph_pkg.sv @@
`timescale 1ns / 1ps

package tph_pkg;

  localparam int SLOT_W = 4;
  localparam logic [13:0] ISN_MODULUS = 14'd10000;

  typedef struct packed {
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic        syn_flag;
    logic        ack_flag;
    logic [13:0] initial_seq;
  } tph_in_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [SLOT_W-1:0] slot_index;
    logic [31:0]       reply_seq;
    logic [31:0]       reply_ack;
  } tph_out_t;

  typedef struct packed {
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [31:0] send_seq;
  } tph_entry_t;

  typedef enum logic [1:0] {
    CONN_CLOSED   = 2'd0,
    CONN_SYN_RCVD = 2'd1,
    CONN_ESTAB    = 2'd2
  } conn_state_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SYNACK = 2'd1,
    ACT_RESET  = 2'd2,
    ACT_ESTAB  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } fsm_t;

endpackage

@@ sv/tcp_passive_handshake_table_unit.sv @@
`timescale 1ns / 1ps
// Each accepted word is scanned against every slot of the table, one slot per
// cycle through one shared compare unit from a single read port, then decided.
// A new word is taken only after the decision, which waits on a full output.
// A finished result waits in the output register while the next word is taken.
// Reset: synchronous on rst_n; all slots closed at once, no clearing pass.
module tcp_passive_handshake_table_unit import tph_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tph_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tph_out_t out_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] N_CNT = CNT_W'(TABLE_ENTRIES);

  fsm_t state_r, state_nxt;

  tph_in_t     item_r;
  logic [CNT_W-1:0] cnt_r;
  logic        cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  conn_state_t st_q_r;
  tph_entry_t  mem_q_r;

  logic        hit_found_r;
  logic [IDX_W-1:0] hit_idx_r;
  conn_state_t hit_st_r;
  logic [31:0] hit_seq_r;
  logic        free_found_r;
  logic [IDX_W-1:0] free_idx_r;

  logic        out_valid_r;
  tph_out_t    out_data_r;

  tph_entry_t  mem [TABLE_ENTRIES];
  conn_state_t conn_state_r [TABLE_ENTRIES];

  logic        accept;
  logic        scan_issue;
  logic        dec_go;
  logic [IDX_W-1:0] rd_addr;

  logic        live;
  logic        match;

  logic [13:0] isn_mod;
  logic [31:0] rx_ack;
  logic [31:0] exp_ack;
  logic        mem_we;
  logic [IDX_W-1:0] wr_idx;
  tph_entry_t  wr_entry;
  conn_state_t wr_state;
  tph_out_t    dec_out;
  logic [IDX_W+SLOT_W-1:0] hit_wide;
  logic [IDX_W+SLOT_W-1:0] free_wide;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!cmp_vld_r && cnt_r == N_CNT) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    scan_issue = 1'b0;
    dec_go     = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = rst_n;
      ST_SCAN:   scan_issue = (cnt_r < N_CNT);
      ST_DECIDE: dec_go = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign accept  = in_valid && in_ready;
  assign rd_addr = cnt_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    mem_q_r <= mem[rd_addr];
    if (mem_we) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        conn_state_r[i] <= CONN_CLOSED;
      end
    end else if (mem_we) begin
      conn_state_r[wr_idx] <= wr_state;
    end
  end

  always_ff @(posedge clk) begin
    st_q_r    <= conn_state_r[rd_addr];
    cmp_idx_r <= rd_addr;
  end

  // shared compare unit: one slot per cycle
  assign live  = (st_q_r != CONN_CLOSED);
  assign match = live && mem_q_r.local_port == item_r.dst_port &&
                 mem_q_r.remote_port == item_r.src_port;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      cmp_vld_r    <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (accept) begin
      cnt_r        <= '0;
      cmp_vld_r    <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      cmp_vld_r <= scan_issue;
      if (scan_issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmp_vld_r && match && !hit_found_r) begin
        hit_found_r <= 1'b1;
      end
      if (cmp_vld_r && !live && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld_r && match && !hit_found_r) begin
      hit_idx_r <= cmp_idx_r;
      hit_st_r  <= st_q_r;
      hit_seq_r <= mem_q_r.send_seq;
    end
    if (cmp_vld_r && !live && !free_found_r) begin
      free_idx_r <= cmp_idx_r;
    end
  end

  assign isn_mod   = (item_r.initial_seq >= ISN_MODULUS) ?
                     item_r.initial_seq - ISN_MODULUS : item_r.initial_seq;
  assign rx_ack    = item_r.seq_num + 32'd1;
  assign exp_ack   = hit_seq_r + 32'd1;
  assign hit_wide  = {{SLOT_W{1'b0}}, hit_idx_r};
  assign free_wide = {{SLOT_W{1'b0}}, free_idx_r};

  always_comb begin
    mem_we     = 1'b0;
    wr_idx     = hit_idx_r;
    wr_state   = CONN_ESTAB;
    wr_entry.local_port  = item_r.dst_port;
    wr_entry.remote_port = item_r.src_port;
    wr_entry.send_seq    = item_r.ack_num;
    dec_out.action     = ACT_NONE;
    dec_out.slot_index = hit_wide[SLOT_W-1:0];
    dec_out.reply_seq  = '0;
    dec_out.reply_ack  = '0;
    if (item_r.syn_flag) begin
      if (!hit_found_r) begin
        if (free_found_r) begin
          mem_we             = dec_go;
          wr_idx             = free_idx_r;
          wr_state           = CONN_SYN_RCVD;
          wr_entry.send_seq  = {18'd0, isn_mod};
          dec_out.action     = ACT_SYNACK;
          dec_out.slot_index = free_wide[SLOT_W-1:0];
          dec_out.reply_seq  = {18'd0, isn_mod};
          dec_out.reply_ack  = rx_ack;
        end else begin
          dec_out.action     = ACT_RESET;
          dec_out.slot_index = '0;
        end
      end
    end else if (!hit_found_r) begin
      dec_out.action     = ACT_RESET;
      dec_out.slot_index = '0;
    end else if (hit_st_r == CONN_SYN_RCVD && item_r.ack_flag &&
                 item_r.ack_num == exp_ack) begin
      mem_we         = dec_go;
      dec_out.action = ACT_ESTAB;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_go) begin
      out_data_r <= dec_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_dec_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    dec_go |=> out_valid)
    else $error("decision did not load the output register");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SCAN && !hit_found_r && !free_found_r && cnt_r == '0))
    else $error("scan did not start clean");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= N_CNT)
    else $error("scan counter ran past the table");

  a_synack_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (dec_go && item_r.syn_flag && !hit_found_r && free_found_r) |=>
      (out_data.action == ACT_SYNACK && conn_state_r[$past(free_idx_r)] == CONN_SYN_RCVD))
    else $error("free slot not taken on SYN");

  a_reply_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.action != ACT_SYNACK) |->
      (out_data.reply_seq == '0 && out_data.reply_ack == '0))
    else $error("reply numbers set without SYN-ACK");

endmodule

@@ tb/tcp_passive_handshake_table_unit_test.sv @@
`timescale 1ns / 1ps

module tcp_passive_handshake_table_unit_test;
  import tph_pkg::*;

  localparam int SLOTS = 16;
  localparam int RANDOM_WORDS = 1024;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    tph_in_t  word;
    bit       typed;
    tph_out_t want;
  } seg_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  tph_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  tph_out_t out_data;

  conn_state_t tbl_state  [SLOTS];
  logic [15:0] tbl_local  [SLOTS];
  logic [15:0] tbl_remote [SLOTS];
  logic [31:0] tbl_snd    [SLOTS];
  logic [31:0] tbl_rcv    [SLOTS];

  tph_out_t pending_replies[$];
  seg_row_t seg_rows[$];
  int       errors = 0;
  int       idle_cycles = 0;
  int       steady_left = 0;
  bit       steady = 1'b0;

  tcp_passive_handshake_table_unit #(.TABLE_ENTRIES(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tph_out_t respond(tph_in_t w);
    tph_out_t r;
    int       hit;
    int       free;
    int       i;
    r = '0;
    hit = -1;
    free = -1;
    for (i = 0; i < SLOTS; i++) begin
      if (hit < 0 && tbl_state[i] != CONN_CLOSED && tbl_local[i] == w.dst_port &&
          tbl_remote[i] == w.src_port)
        hit = i;
      if (free < 0 && tbl_state[i] == CONN_CLOSED)
        free = i;
    end
    if (w.syn_flag) begin
      if (hit >= 0) begin
        r.action = ACT_NONE;
        r.slot_index = hit[3:0];
      end else if (free < 0) begin
        r.action = ACT_RESET;
      end else begin
        tbl_state[free]  = CONN_SYN_RCVD;
        tbl_local[free]  = w.dst_port;
        tbl_remote[free] = w.src_port;
        tbl_rcv[free]    = w.seq_num + 32'd1;
        tbl_snd[free]    = 32'(w.initial_seq) % 32'(ISN_MODULUS);
        r.action     = ACT_SYNACK;
        r.slot_index = free[3:0];
        r.reply_seq  = tbl_snd[free];
        r.reply_ack  = tbl_rcv[free];
      end
    end else if (hit < 0) begin
      r.action = ACT_RESET;
    end else begin
      r.slot_index = hit[3:0];
      if (tbl_state[hit] == CONN_SYN_RCVD && w.ack_flag &&
          w.ack_num == tbl_snd[hit] + 32'd1) begin
        tbl_state[hit] = CONN_ESTAB;
        tbl_snd[hit]   = w.ack_num;
        r.action = ACT_ESTAB;
      end else begin
        r.action = ACT_NONE;
      end
    end
    return r;
  endfunction

  function automatic tph_in_t segment(logic [15:0] src, logic [15:0] dst, logic [31:0] seq,
                                      logic [31:0] ack, logic syn, logic ackf,
                                      logic [13:0] isn);
    tph_in_t w;
    w.src_port    = src;
    w.dst_port    = dst;
    w.seq_num     = seq;
    w.ack_num     = ack;
    w.syn_flag    = syn;
    w.ack_flag    = ackf;
    w.initial_seq = isn;
    return w;
  endfunction

  function automatic tph_out_t reply(action_t act, logic [3:0] slot, logic [31:0] rseq,
                                     logic [31:0] rack);
    tph_out_t r;
    r.action     = act;
    r.slot_index = slot;
    r.reply_seq  = rseq;
    r.reply_ack  = rack;
    return r;
  endfunction

  function automatic void add_row(tph_in_t w, bit typed = 1'b0, tph_out_t want = '0);
    seg_row_t row;
    row.word  = w;
    row.typed = typed;
    row.want  = want;
    seg_rows.push_back(row);
  endfunction

  task automatic send_word(tph_in_t w, bit typed, tph_out_t want);
    int       gap;
    tph_out_t pred;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    pred = respond(w);
    pending_replies.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (steady_left == 0) begin
      steady      <= ($urandom_range(0, 3) == 0);
      steady_left <= $urandom_range(20, 200);
    end else begin
      steady_left <= steady_left - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[tcp_passive_handshake_table_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    tph_out_t want;
    int       stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_replies.size() == 0) begin
        $error("unexpected reply word: action %0d slot %0d", out_data.action,
               out_data.slot_index);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (out_data.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, out_data.action);
          errors++;
        end
        if (out_data.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, out_data.slot_index);
          errors++;
        end
        if (out_data.reply_seq !== want.reply_seq) begin
          $error("reply_seq: expected %0h, got %0h", want.reply_seq, out_data.reply_seq);
          errors++;
        end
        if (out_data.reply_ack !== want.reply_ack) begin
          $error("reply_ack: expected %0h, got %0h", want.reply_ack, out_data.reply_ack);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    tph_in_t w;
    int      kind;
    int      s;
    int      k;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    for (k = 0; k < SLOTS; k++)
      tbl_state[k] = CONN_CLOSED;

    add_row(segment(16'h0000, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b1, 14'd0), 1'b1,
            reply(ACT_RESET, 4'd0, 32'd0, 32'd0));
    add_row(segment(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 14'd16383),
            1'b1, reply(ACT_SYNACK, 4'd0, 32'd6383, 32'd0));
    add_row(segment(16'hFFFF, 16'hFFFF, 32'h1234_5678, 32'h0, 1'b1, 1'b0, 14'd77), 1'b1,
            reply(ACT_NONE, 4'd0, 32'd0, 32'd0));
    add_row(segment(16'hFFFF, 16'hFFFF, 32'h0, 32'd6383, 1'b0, 1'b1, 14'd0));
    add_row(segment(16'hFFFF, 16'hFFFF, 32'h0, 32'd6384, 1'b0, 1'b0, 14'd0));
    add_row(segment(16'hFFFF, 16'hFFFF, 32'h0, 32'd6384, 1'b0, 1'b1, 14'd0), 1'b1,
            reply(ACT_ESTAB, 4'd0, 32'd0, 32'd0));
    add_row(segment(16'hFFFF, 16'hFFFF, 32'h0, 32'd6384, 1'b1, 1'b1, 14'd9));
    add_row(segment(16'h0000, 16'h0000, 32'h0, 32'h0, 1'b1, 1'b0, 14'd0), 1'b1,
            reply(ACT_SYNACK, 4'd1, 32'd0, 32'd1));
    add_row(segment(16'd1, 16'd80, 32'd1000, 32'h0, 1'b1, 1'b0, 14'd9999), 1'b1,
            reply(ACT_SYNACK, 4'd2, 32'd9999, 32'd1001));
    add_row(segment(16'd2, 16'd80, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0, 14'd10000), 1'b1,
            reply(ACT_SYNACK, 4'd3, 32'd0, 32'h8000_0000));
    add_row(segment(16'd2, 16'd80, 32'h8000_0000, 32'd1, 1'b0, 1'b1, 14'd0), 1'b1,
            reply(ACT_ESTAB, 4'd3, 32'd0, 32'd0));
    add_row(segment(16'd80, 16'd1, 32'd1001, 32'd10000, 1'b0, 1'b1, 14'd0), 1'b1,
            reply(ACT_RESET, 4'd0, 32'd0, 32'd0));
    add_row(segment(16'd3, 16'd80, 32'd100, 32'hFFFF_FFFF, 1'b1, 1'b1, 14'd5));
    add_row(segment(16'd3, 16'd80, 32'd101, 32'd6, 1'b1, 1'b1, 14'd5));
    for (k = 0; k < 11; k++)
      add_row(segment(16'h4000 + 16'(k) * 16'h0F0F, 16'hC000 | 16'(k),
                      32'hA5A5_0000 ^ 32'(k), 32'(k), 1'b1, k[0], 14'(1000 * k + 7)));
    add_row(segment(16'h1234, 16'h5678, 32'h0, 32'h0, 1'b1, 1'b0, 14'd42), 1'b1,
            reply(ACT_RESET, 4'd0, 32'd0, 32'd0));

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (seg_rows[i])
      send_word(seg_rows[i].word, seg_rows[i].typed, seg_rows[i].want);

    for (k = 0; k < RANDOM_WORDS; k++) begin
      w = segment(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), $urandom,
                  $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  14'($urandom_range(0, 16383)));
      kind = $urandom_range(0, 9);
      s = $urandom_range(0, SLOTS - 1);
      if (kind < 6 && tbl_state[s] != CONN_CLOSED) begin
        w.src_port = tbl_remote[s];
        w.dst_port = tbl_local[s];
        w.syn_flag = ($urandom_range(0, 4) == 0);
        if (tbl_state[s] == CONN_SYN_RCVD && $urandom_range(0, 3) == 0) begin
          w.ack_flag = ($urandom_range(0, 5) != 0);
          w.ack_num  = tbl_snd[s] + 32'($urandom_range(0, 2));
        end
      end else if (kind < 8 && tbl_state[s] != CONN_CLOSED) begin
        w.src_port = tbl_local[s];
        w.dst_port = tbl_remote[s];
      end
      send_word(w, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[tcp_passive_handshake_table_unit] OK");
    else
      $display("[tcp_passive_handshake_table_unit] ERROR");
    $finish;
  end

endmodule
